// File: hdl/sac_pkg.sv
// Shared types, constants and register codes for the set-associative cache tag lookup.
// Used by the interfaces, the way-select unit, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package sac_pkg;

  // Default sizes of the tag store and the address.
  localparam int unsigned ADDR_BITS_DEF = 12;
  localparam int unsigned MAX_SETS_DEF  = 16;
  localparam int unsigned MAX_WAYS_DEF  = 4;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // Register widths.
  localparam int unsigned OFF_W   = 4;
  localparam int unsigned IDXW_W  = 3;
  localparam int unsigned WAYS_W  = 3;
  localparam int unsigned HCOST_W = 8;
  localparam int unsigned MCOST_W = 10;

  // Register reset values.
  localparam logic [OFF_W-1:0]   OFF_RST   = 4'd5;
  localparam logic [IDXW_W-1:0]  IDXW_RST  = 3'd3;
  localparam logic [WAYS_W-1:0]  WAYS_RST  = 3'd1;
  localparam logic [HCOST_W-1:0] HCOST_RST = 8'd5;
  localparam logic [MCOST_W-1:0] MCOST_RST = 10'd103;

  // The set field can be up to 2**IDXW_W - 1 bits wide.
  localparam int unsigned IDX_FIELD_W = 7;
  // Wide enough for the clamped way count (up to eight ways).
  localparam int unsigned NWAYS_W = 4;
  // Shift amount for the tag: offset width plus index width.
  localparam int unsigned TSH_W = 5;

  localparam int unsigned CNT_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_WIDTH = 3'd0,
    CFG_INDEX_WIDTH  = 3'd1,
    CFG_WAYS_IN_USE  = 3'd2,
    CFG_HIT_COST     = 3'd3,
    CFG_MISS_COST    = 3'd4
  } cfg_idx_e;

  // Outcome of one set lookup.
  typedef struct packed {
    logic hit;
    logic evict;
  } sac_look_t;

endpackage

`default_nettype wire

// File: hdl/sac_if.sv
// Valid/ready channel interfaces for the cache tag lookup: address in, result out.
// Depends on sac_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

interface sac_in_if import sac_pkg::*; #(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface sac_out_if import sac_pkg::*; #(
  parameter int unsigned WAY_W = 2,
  parameter int unsigned SET_W = 4
) ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [WAY_W-1:0] way_used;
  logic [SET_W-1:0] set_used;
  logic             evicted_valid;
  logic [CNT_W-1:0] total_ticks;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;

  modport source (output valid, output hit, output way_used, output set_used,
                  output evicted_valid, output total_ticks, output hit_total,
                  output miss_total, input ready);
  modport sink   (input valid, input hit, input way_used, input set_used,
                  input evicted_valid, input total_ticks, input hit_total,
                  input miss_total, output ready);
endinterface

`default_nettype wire

// File: hdl/sac_way_sel.sv
// Tag compare, victim choice and LRU age update for one set row.
// Depends on sac_pkg for the lookup outcome struct.
`timescale 1ns / 1ps
`default_nettype none

module sac_way_sel import sac_pkg::*; #(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF,
  parameter int unsigned MAX_WAYS  = MAX_WAYS_DEF,
  localparam int unsigned WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tags_i,
  input  logic [MAX_WAYS-1:0]                valid_i,
  input  logic [MAX_WAYS-1:0][WAY_W-1:0]     ages_i,
  input  logic [ADDR_BITS-1:0]               tag_i,
  input  logic [NWAYS_W-1:0]                 nways_i,
  output sac_look_t                          res_o,
  output logic [WAY_W-1:0]                   way_o,
  output logic [MAX_WAYS-1:0][WAY_W-1:0]     ages_o
);

  logic [MAX_WAYS-1:0] in_use;
  logic                hit_found;
  logic [WAY_W-1:0]    hit_way;
  logic                inv_found;
  logic [WAY_W-1:0]    inv_way;
  logic [WAY_W-1:0]    old_way;
  logic [WAY_W-1:0]    old_age;
  logic [WAY_W-1:0]    sel_way;
  logic [WAY_W-1:0]    sel_age;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = NWAYS_W'(w) < nways_i;
    end
  end

  // Lowest matching way wins; lowest invalid way is filled first.
  always_comb begin
    hit_found = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && valid_i[w] && (tags_i[w] == tag_i) && !hit_found) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(w);
      end
      if (in_use[w] && !valid_i[w] && !inv_found) begin
        inv_found = 1'b1;
        inv_way   = WAY_W'(w);
      end
    end
  end

  // Oldest way in use, lowest way on a tie. Way 0 is always in use.
  always_comb begin
    old_way = '0;
    old_age = ages_i[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use[w] && (ages_i[w] > old_age)) begin
        old_way = WAY_W'(w);
        old_age = ages_i[w];
      end
    end
  end

  always_comb begin
    res_o.hit   = hit_found;
    res_o.evict = !hit_found && !inv_found;
    if (hit_found) begin
      sel_way = hit_way;
    end else if (inv_found) begin
      sel_way = inv_way;
    end else begin
      sel_way = old_way;
    end
    way_o = sel_way;
  end

  // Every way younger than the touched one ages by one; the touched way becomes newest.
  always_comb begin
    sel_age = ages_i[sel_way];
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (ages_i[w] < sel_age) begin
        ages_o[w] = ages_i[w] + WAY_W'(1);
      end else begin
        ages_o[w] = ages_i[w];
      end
    end
    ages_o[sel_way] = '0;
  end

endmodule

`default_nettype wire

// File: hdl/set_assoc_cache_tag_lookup.sv
// Top level of the set-associative cache tag lookup with per-set LRU replacement.
// Depends on sac_pkg, the sac_in_if/sac_out_if interfaces and sac_way_sel.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Direction  Handshake        Payload
//  in_i      sink       valid / ready    address
//  out_o     source     valid / ready    hit, way_used, set_used, evicted_valid,
//                                        total_ticks, hit_total, miss_total
//  cfg       write      cfg_we_i         cfg_idx_i, cfg_wdata_i
//
//  Each item first reads its set row from the single-port tag memory, then compares,
//  chooses the way and writes the updated row back.
//  After reset the block sweeps the tag memory, one set per cycle, marking every line
//  invalid and restoring the ages; no item is accepted meanwhile.
//  A new item may be accepted while a finished result still waits on out_o. Its lookup
//  then holds, with the row it read, until the output register frees up.

module set_assoc_cache_tag_lookup import sac_pkg::*; #(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF,
  parameter int unsigned MAX_SETS  = MAX_SETS_DEF,
  parameter int unsigned MAX_WAYS  = MAX_WAYS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  sac_in_if.sink                in_i,
  sac_out_if.source             out_o
);

  localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned TAG_VW = MAX_WAYS * ADDR_BITS;
  localparam int unsigned AGE_VW = MAX_WAYS * WAY_W;
  localparam int unsigned ROW_W  = AGE_VW + MAX_WAYS + TAG_VW;
  localparam int unsigned LUT_N  = 2 ** IDX_FIELD_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_e;

  // Configuration registers.
  logic [OFF_W-1:0]   off_q;
  logic [IDXW_W-1:0]  idxw_q;
  logic [WAYS_W-1:0]  ways_q;
  logic [HCOST_W-1:0] hcost_q;
  logic [MCOST_W-1:0] mcost_q;

  // Control and result registers.
  state_e             state_q;
  logic [SET_W-1:0]   clr_q;
  logic [SET_W-1:0]   set_q;
  logic [ADDR_BITS-1:0] tag_q;
  logic               out_vld_q;
  logic               hit_q;
  logic               evict_q;
  logic [WAY_W-1:0]   way_q;
  logic [SET_W-1:0]   oset_q;
  logic [CNT_W-1:0]   ticks_q;
  logic [CNT_W-1:0]   hits_q;
  logic [CNT_W-1:0]   misses_q;

  // Tag memory: one row per set holding ages, valid bits and tags of all ways.
  logic [ROW_W-1:0]   mem_q [MAX_SETS];
  logic [ROW_W-1:0]   rd_q;
  logic               mem_we;
  logic [SET_W-1:0]   mem_waddr;
  logic [ROW_W-1:0]   mem_wdata;

  // Address split.
  logic [ADDR_BITS-1:0]   addr_sh;
  logic [IDX_FIELD_W:0]   idx_one;
  logic [IDX_FIELD_W-1:0] idx_mask;
  logic [IDX_FIELD_W-1:0] idx_field;
  logic [SET_W-1:0]       set_lut [LUT_N];
  logic [SET_W-1:0]       set_d;
  logic [TSH_W-1:0]       tag_sh;
  logic [ADDR_BITS-1:0]   tag_d;

  // Lookup of the row just read.
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] rd_tags;
  logic [MAX_WAYS-1:0]                rd_vld;
  logic [MAX_WAYS-1:0][WAY_W-1:0]     rd_ages;
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] new_tags;
  logic [MAX_WAYS-1:0]                new_vld;
  logic [MAX_WAYS-1:0][WAY_W-1:0]     new_ages;
  logic [MAX_WAYS-1:0][WAY_W-1:0]     rst_ages;
  logic [NWAYS_W-1:0]                 nways;
  sac_look_t                          look;
  logic [WAY_W-1:0]                   look_way;

  logic in_acc;
  logic look_done;
  logic [CNT_W-1:0] ticks_d;
  logic [CNT_W-1:0] hits_d;
  logic [CNT_W-1:0] misses_d;

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration writes. Unknown indexes are ignored.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= OFF_RST;
      idxw_q  <= IDXW_RST;
      ways_q  <= WAYS_RST;
      hcost_q <= HCOST_RST;
      mcost_q <= MCOST_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OFFSET_WIDTH: off_q   <= cfg_wdata_i[OFF_W-1:0];
        CFG_INDEX_WIDTH:  idxw_q  <= cfg_wdata_i[IDXW_W-1:0];
        CFG_WAYS_IN_USE:  ways_q  <= cfg_wdata_i[WAYS_W-1:0];
        CFG_HIT_COST:     hcost_q <= cfg_wdata_i[HCOST_W-1:0];
        CFG_MISS_COST:    mcost_q <= cfg_wdata_i[MCOST_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Address split. The set field is up to seven bits wide; a value at or above
  // MAX_SETS wraps around, which a constant table resolves. Bits shifted in from
  // above the address read as zero.
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < LUT_N; g++) begin : g_set_lut
    assign set_lut[g] = SET_W'(g % MAX_SETS);
  end

  always_comb begin
    addr_sh   = in_i.address >> off_q;
    idx_one   = {{IDX_FIELD_W{1'b0}}, 1'b1} << idxw_q;
    // Index width seven leaves the low bits of idx_one at zero, which still gives all ones.
    idx_mask  = idx_one[IDX_FIELD_W-1:0] - IDX_FIELD_W'(1);
    idx_field = addr_sh[IDX_FIELD_W-1:0] & idx_mask;
    set_d     = set_lut[idx_field];
    tag_sh    = TSH_W'(off_q) + TSH_W'(idxw_q);
    tag_d     = in_i.address >> tag_sh;
  end

  // Way count in use: zero acts as one, anything above MAX_WAYS saturates.
  always_comb begin
    if (ways_q == '0) begin
      nways = NWAYS_W'(1);
    end else if (NWAYS_W'(ways_q) > NWAYS_W'(MAX_WAYS)) begin
      nways = NWAYS_W'(MAX_WAYS);
    end else begin
      nways = NWAYS_W'(ways_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Row lookup and update.
  // ---------------------------------------------------------------------------
  assign rd_tags = rd_q[TAG_VW-1:0];
  assign rd_vld  = rd_q[TAG_VW +: MAX_WAYS];
  assign rd_ages = rd_q[TAG_VW + MAX_WAYS +: AGE_VW];

  sac_way_sel #(
    .ADDR_BITS (ADDR_BITS),
    .MAX_WAYS  (MAX_WAYS)
  ) u_way_sel (
    .tags_i  (rd_tags),
    .valid_i (rd_vld),
    .ages_i  (rd_ages),
    .tag_i   (tag_q),
    .nways_i (nways),
    .res_o   (look),
    .way_o   (look_way),
    .ages_o  (new_ages)
  );

  always_comb begin
    new_tags = rd_tags;
    new_vld  = rd_vld;
    if (!look.hit) begin
      new_tags[look_way] = tag_q;
    end
    new_vld[look_way] = 1'b1;
  end

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      rst_ages[w] = WAY_W'(w);
    end
  end

  always_comb begin
    if (look.hit) begin
      ticks_d  = sat_add(ticks_q, CNT_W'(hcost_q));
      hits_d   = sat_add(hits_q, CNT_W'(1));
      misses_d = misses_q;
    end else begin
      ticks_d  = sat_add(ticks_q, CNT_W'(mcost_q));
      hits_d   = hits_q;
      misses_d = sat_add(misses_q, CNT_W'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // Handshakes. One item is in flight at a time; its lookup finishes once the
  // output register is empty or being emptied in the same cycle.
  // ---------------------------------------------------------------------------
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign look_done  = (state_q == ST_LOOK) && (!out_vld_q || out_o.ready);

  // Memory writes come from the clearing sweep or from a finished lookup.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = set_q;
    mem_wdata = {new_ages, new_vld, new_tags};
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = {rst_ages, {MAX_WAYS{1'b0}}, {TAG_VW{1'b0}}};
    end else if (look_done) begin
      mem_we = 1'b1;
    end
  end

  // Reads are issued on accept and writes only in the other states, so a read never
  // meets a write to the same row in one cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rd_q <= mem_q[set_d];
    end
  end

  // Accepted item's tag and set; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      set_q <= set_d;
      tag_q <= tag_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer, counters and the output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      evict_q   <= 1'b0;
      way_q     <= '0;
      oset_q    <= '0;
      ticks_q   <= '0;
      hits_q    <= '0;
      misses_q  <= '0;
    end else begin
      if (out_vld_q && out_o.ready && !look_done) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_q == SET_W'(MAX_SETS - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            clr_q <= clr_q + SET_W'(1);
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (look_done) begin
            state_q   <= ST_IDLE;
            out_vld_q <= 1'b1;
            hit_q     <= look.hit;
            evict_q   <= look.evict;
            way_q     <= look_way;
            oset_q    <= set_q;
            ticks_q   <= ticks_d;
            hits_q    <= hits_d;
            misses_q  <= misses_d;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.hit           = hit_q;
  assign out_o.way_used      = way_q;
  assign out_o.set_used      = oset_q;
  assign out_o.evicted_valid = evict_q;
  assign out_o.total_ticks   = ticks_q;
  assign out_o.hit_total     = hits_q;
  assign out_o.miss_total    = misses_q;

endmodule

`default_nettype wire

// File: hdl/sac_checker.sv
// Port-level checker for the cache tag lookup, bound to the top level.
// Depends on sac_pkg for the counter width.
`timescale 1ns / 1ps
`default_nettype none

module sac_checker import sac_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             out_hit_i,
  input logic             out_evict_i,
  input logic [CNT_W-1:0] out_ticks_i,
  input logic [CNT_W-1:0] out_hits_i
);

  // A result that is not taken stays, with its running total.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_ticks_i))
    else $error("result dropped or changed while stalled");

  // A hit never reports an eviction.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_hit_i |-> !out_evict_i)
    else $error("hit reported together with an eviction");

  // Only one item is looked up at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item accepted during a lookup");

  // The hit count never goes backwards from one result to the next.
  a_hits_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> !out_valid_i || (out_hits_i >= $past(out_hits_i)))
    else $error("hit count decreased");

endmodule

bind set_assoc_cache_tag_lookup sac_checker u_sac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_hit_i   (out_o.hit),
  .out_evict_i (out_o.evicted_valid),
  .out_ticks_i (out_o.total_ticks),
  .out_hits_i  (out_o.hit_total)
);

`default_nettype wire

// File: bench/set_assoc_cache_tag_lookup_tb.sv
// Self-checking testbench for the set-associative cache tag lookup with per-set LRU.
// Depends on sac_pkg, the sac_in_if/sac_out_if interfaces and the top-level RTL.
`timescale 1ns / 1ps

module set_assoc_cache_tag_lookup_tb;
  import sac_pkg::*;

  localparam int unsigned AW = ADDR_BITS_DEF;

  // One lookup outcome, laid out like the result channel.
  typedef struct packed {
    logic             hit;
    logic [1:0]       way_used;
    logic [3:0]       set_used;
    logic             evicted_valid;
    logic [CNT_W-1:0] total_ticks;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
  } lookup_res_t;

  // Ready patterns of the result side; each one runs for a random stretch.
  typedef enum int unsigned {
    RX_EAGER,
    RX_HALF,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sac_in_if  in_ch ();
  sac_out_if out_ch ();

  set_assoc_cache_tag_lookup uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Addresses waiting to be offered, and outcomes waiting to come out.
  logic [AW-1:0] pending_addrs [$];
  lookup_res_t   outcomes_due [$];

  // Set by the monitor at the rising edge, read by the driver at the falling edge.
  bit          took_addr;
  int unsigned mismatches;

  // Requests for a long hold-off on the result side, and how many were served.
  int unsigned choke_asks;
  int unsigned choke_seen;

  // Shadow copy of the configuration registers, updated as the block sees writes.
  logic [OFF_W-1:0]   off_cfg;
  logic [IDXW_W-1:0]  idx_cfg;
  logic [WAYS_W-1:0]  ways_cfg;
  logic [HCOST_W-1:0] hcost_cfg;
  logic [MCOST_W-1:0] mcost_cfg;

  // Shadow copy of the tag store, the valid bits, the ages and the counters.
  logic [AW-1:0]    tag_mem    [MAX_SETS_DEF][MAX_WAYS_DEF];
  bit               line_valid [MAX_SETS_DEF][MAX_WAYS_DEF];
  bit [1:0]         line_age   [MAX_SETS_DEF][MAX_WAYS_DEF];
  logic [CNT_W-1:0] tick_sum;
  logic [CNT_W-1:0] hits_sum;
  logic [CNT_W-1:0] misses_sum;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Adds and sticks at the all-ones value instead of wrapping.
  function automatic logic [CNT_W-1:0] sat_sum(logic [CNT_W-1:0] acc, int unsigned inc);
    longint unsigned s;
    s = longint'(acc) + longint'(inc);
    return (s > 64'hFFFF_FFFF) ? '1 : s[CNT_W-1:0];
  endfunction

  // Works out the outcome of one access and updates the shadow store with it.
  function automatic lookup_res_t cache_access(logic [AW-1:0] addr);
    int unsigned nways;
    int unsigned set_no;
    int unsigned tag;
    int unsigned way;
    int unsigned w;
    bit          hit;
    bit          evict;
    bit          found;
    bit [1:0]    old_age;
    lookup_res_t res;

    // A way count of zero means one way; counts above the store's ways are clamped.
    nways = 32'(ways_cfg);
    if (nways == 0) nways = 1;
    if (nways > MAX_WAYS_DEF) nways = MAX_WAYS_DEF;

    // Oversized widths simply shift zeros in; a set number past the store wraps.
    set_no = ((32'(addr) >> off_cfg) & ((32'd1 << idx_cfg) - 1)) % MAX_SETS_DEF;
    tag    = (32'(addr) >> (32'(off_cfg) + 32'(idx_cfg))) & ((32'd1 << AW) - 1);

    hit   = 1'b0;
    evict = 1'b0;
    found = 1'b0;
    way   = 0;
    // After a width change several ways may match; the lowest one wins.
    for (w = 0; w < nways; w++) begin
      if (!hit && line_valid[set_no][w] && 32'(tag_mem[set_no][w]) == tag) begin
        hit = 1'b1;
        way = w;
      end
    end

    if (hit) begin
      tick_sum = sat_sum(tick_sum, 32'(hcost_cfg));
      hits_sum = sat_sum(hits_sum, 1);
    end else begin
      // Fill the lowest empty way first; otherwise evict the oldest, lowest on a tie.
      for (w = 0; w < nways; w++) begin
        if (!found && !line_valid[set_no][w]) begin
          found = 1'b1;
          way   = w;
        end
      end
      if (!found) begin
        way = 0;
        for (w = 1; w < nways; w++) begin
          if (line_age[set_no][w] > line_age[set_no][way]) way = w;
        end
        evict = 1'b1;
      end
      tag_mem[set_no][way]    = tag[AW-1:0];
      line_valid[set_no][way] = 1'b1;
      tick_sum   = sat_sum(tick_sum, 32'(mcost_cfg));
      misses_sum = sat_sum(misses_sum, 1);
    end

    // The touched way becomes the youngest; younger ways in the set age by one.
    old_age = line_age[set_no][way];
    for (w = 0; w < MAX_WAYS_DEF; w++) begin
      if (line_age[set_no][w] < old_age) line_age[set_no][w]++;
    end
    line_age[set_no][way] = 2'd0;

    res.hit           = hit;
    res.way_used      = way[1:0];
    res.set_used      = set_no[3:0];
    res.evicted_valid = evict;
    res.total_ticks   = tick_sum;
    res.hit_total     = hits_sum;
    res.miss_total    = misses_sum;
    return res;
  endfunction

  task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: mirrors register writes, checks each result against the oldest outcome
  // due, and predicts the outcome of each address the block takes.
  always @(posedge clk_i) begin
    int unsigned s;
    int unsigned w;
    lookup_res_t want;
    if (!rst_ni) begin
      off_cfg    = OFF_RST;
      idx_cfg    = IDXW_RST;
      ways_cfg   = WAYS_RST;
      hcost_cfg  = HCOST_RST;
      mcost_cfg  = MCOST_RST;
      tick_sum   = '0;
      hits_sum   = '0;
      misses_sum = '0;
      for (s = 0; s < MAX_SETS_DEF; s++) begin
        for (w = 0; w < MAX_WAYS_DEF; w++) begin
          tag_mem[s][w]    = '0;
          line_valid[s][w] = 1'b0;
          line_age[s][w]   = w[1:0];
        end
      end
      took_addr = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_OFFSET_WIDTH: off_cfg   = cfg_wdata[OFF_W-1:0];
          CFG_INDEX_WIDTH:  idx_cfg   = cfg_wdata[IDXW_W-1:0];
          CFG_WAYS_IN_USE:  ways_cfg  = cfg_wdata[WAYS_W-1:0];
          CFG_HIT_COST:     hcost_cfg = cfg_wdata[HCOST_W-1:0];
          CFG_MISS_COST:    mcost_cfg = cfg_wdata[MCOST_W-1:0];
          default: ;
        endcase
      end

      took_addr = in_ch.valid && in_ch.ready;

      if (out_ch.valid && out_ch.ready) begin
        if (outcomes_due.size() == 0) begin
          $error("result item arrived with no outcome expected");
          mismatches++;
        end else begin
          want = outcomes_due.pop_front();
          check_field("hit", CNT_W'(want.hit), CNT_W'(out_ch.hit));
          check_field("way_used", CNT_W'(want.way_used), CNT_W'(out_ch.way_used));
          check_field("set_used", CNT_W'(want.set_used), CNT_W'(out_ch.set_used));
          check_field("evicted_valid", CNT_W'(want.evicted_valid),
                      CNT_W'(out_ch.evicted_valid));
          check_field("total_ticks", want.total_ticks, out_ch.total_ticks);
          check_field("hit_total", want.hit_total, out_ch.hit_total);
          check_field("miss_total", want.miss_total, out_ch.miss_total);
        end
      end

      if (took_addr) outcomes_due.push_back(cache_access(in_ch.address));
    end
  end

  // Driver: offers addresses in bursts of random length with random gaps between.
  // A valid item is held until the block has taken it.
  int unsigned burst_left;
  int unsigned gap_left;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_ch.valid || took_addr) begin
      if (gap_left != 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_addrs.size() != 0) begin
        in_ch.valid   <= 1'b1;
        in_ch.address <= pending_addrs.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          // Mostly short gaps, now and then a long one.
          gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(0, 4);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: switches between ready patterns at random. When a hold-off is requested
  // it keeps ready low for a long stretch so that the block fills up and has to stall
  // its input.
  rx_mode_e    rx_mode;
  int unsigned mode_left;
  int unsigned choke_left;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      rx_mode    = RX_EAGER;
      mode_left  = 0;
      choke_left = 0;
    end else begin
      if (choke_seen != choke_asks) begin
        choke_seen = choke_asks;
        choke_left = $urandom_range(60, 120);
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      if (choke_left != 0) begin
        choke_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_EAGER:  out_ch.ready <= 1'b1;
          RX_HALF:   out_ch.ready <= ($urandom_range(0, 1) == 0);
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Waits until no address is pending or in flight and every outcome has come out,
  // then lets the clock run on so the block is surely quiet.
  task automatic wait_idle();
    while (pending_addrs.size() != 0 || in_ch.valid || outcomes_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
  endtask

  // Rewrites all five registers while the block is idle. The store is not flushed,
  // so lines from the previous setting stay and may now alias differently.
  task automatic set_config(int unsigned off, int unsigned idx, int unsigned ways,
                            int unsigned hc, int unsigned mc);
    wait_idle();
    write_reg(CFG_OFFSET_WIDTH, off);
    write_reg(CFG_INDEX_WIDTH, idx);
    write_reg(CFG_WAYS_IN_USE, ways);
    write_reg(CFG_HIT_COST, hc);
    write_reg(CFG_MISS_COST, mc);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stimulus: a short directed run, then phases of random accesses, each under its
  // own setting of the registers.
  initial begin : stimulus
    logic [AW-1:0] directed_addrs [$];
    logic [AW-1:0] pool [24];
    int unsigned   phase_cfg [8][5];
    int unsigned   pool_n;
    int unsigned   p;
    int unsigned   i;

    in_ch.valid   = 1'b0;
    in_ch.address = '0;
    out_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_OFFSET_WIDTH;
    cfg_wdata     = '0;
    choke_asks    = 0;
    choke_seen    = 0;
    mismatches    = 0;
    took_addr     = 1'b0;

    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed run with two-bit offset and index and two ways, so the set is
    // address bits 3:2 and the tag is bits 11:4. It covers a cold miss, a hit on
    // the same line and on another byte of it, the all-ones address, two fills of
    // one set followed by evictions of the least recently used way, and single bits.
    directed_addrs = '{12'h000, 12'h000, 12'h003, 12'hFFF, 12'hFFC, 12'h010,
                       12'h020, 12'h000, 12'h010, 12'h555, 12'hAAA, 12'h800,
                       12'h400, 12'h200, 12'h100, 12'h080, 12'h040, 12'h020,
                       12'h001, 12'hFFF, 12'h7FF};
    set_config(2, 2, 2, 255, 0);
    foreach (directed_addrs[k]) pending_addrs.push_back(directed_addrs[k]);

    // Offset width, index width, ways, hit cost, miss cost for each random phase.
    // Phase 0 restores the reset values, phase 1 is fully associative with extreme
    // costs, phase 3 has every width far past the address so all accesses share one
    // line, phases 4 and 5 use three ways and zero ways, phase 5 an index wider than
    // the store. The costs of phases 3 and 4 and all of phase 7 are drawn at random.
    phase_cfg = '{'{5, 3, 1,   5,  103},
                  '{0, 0, 4,   0, 1023},
                  '{8, 4, 2, 255,    0},
                  '{15, 7, 7,  0,    0},
                  '{3, 1, 3,   0,    0},
                  '{4, 5, 0,  17,  250},
                  '{1, 2, 4,   1,    1},
                  '{0, 0, 0,   0,    0}};
    for (p = 3; p <= 4; p++) begin
      phase_cfg[p][3] = $urandom_range(0, 255);
      phase_cfg[p][4] = $urandom_range(0, 1023);
    end
    phase_cfg[7] = '{$urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 7),
                     $urandom_range(0, 255), $urandom_range(0, 1023)};

    for (p = 0; p < 8; p++) begin
      set_config(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2],
                 phase_cfg[p][3], phase_cfg[p][4]);
      // A small working set gives hits and evictions; about one access in five is a
      // fresh random address. Nearby bytes of a pool entry share its line unless
      // the offset is narrow.
      pool_n = $urandom_range(2, 24);
      for (i = 0; i < pool_n; i++) pool[i] = AW'($urandom_range(0, (1 << AW) - 1));
      repeat (105) begin
        if ($urandom_range(0, 9) < 8)
          pending_addrs.push_back(pool[$urandom_range(0, pool_n - 1)] ^
                                  AW'($urandom_range(0, 7)));
        else
          pending_addrs.push_back(AW'($urandom_range(0, (1 << AW) - 1)));
      end
      // Hold the result side off while a full phase of addresses is queued.
      if (p == 0 || p == 4) choke_asks++;
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && outcomes_due.size() == 0) begin
      $display("set_assoc_cache_tag_lookup_tb passed");
    end else begin
      $display("set_assoc_cache_tag_lookup_tb failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("set_assoc_cache_tag_lookup_tb failed");
    $finish;
  end

endmodule
